@@ rtl/kts_pkg.sv @@
// ----------------------------------------------------------------------------
// kts_pkg
// shared types, token kind codes and keyword tables for the token scanner
// ----------------------------------------------------------------------------
package kts_pkg;

	// longest token length counted, longer tokens saturate here
	localparam int unsigned MAX_TOKEN_LENGTH = 255;
	localparam int unsigned LEN_W            = $clog2(MAX_TOKEN_LENGTH + 1);

	localparam int unsigned KW_COUNT = 5;
	localparam logic [KW_COUNT-1:0] KW_ALL = '1;

	// result queue
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	// token kind codes
	localparam logic [4:0] K_INT    = 5'd0;
	localparam logic [4:0] K_MAIN   = 5'd1;
	localparam logic [4:0] K_IF     = 5'd2;
	localparam logic [4:0] K_ELSE   = 5'd3;
	localparam logic [4:0] K_WHILE  = 5'd4;
	localparam logic [4:0] K_ID     = 5'd5;
	localparam logic [4:0] K_LIT    = 5'd6;
	localparam logic [4:0] K_LPAREN = 5'd7;
	localparam logic [4:0] K_RPAREN = 5'd8;
	localparam logic [4:0] K_LBRACE = 5'd9;
	localparam logic [4:0] K_RBRACE = 5'd10;
	localparam logic [4:0] K_SEMI   = 5'd11;
	localparam logic [4:0] K_EQEQ   = 5'd12;
	localparam logic [4:0] K_GE     = 5'd13;
	localparam logic [4:0] K_LE     = 5'd14;
	localparam logic [4:0] K_GT     = 5'd15;
	localparam logic [4:0] K_LT     = 5'd16;
	localparam logic [4:0] K_ASSIGN = 5'd17;
	localparam logic [4:0] K_PLUS   = 5'd18;
	localparam logic [4:0] K_MINUS  = 5'd19;

	// source characters of interest
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_LIT,
		MODE_EQ,
		MODE_LT,
		MODE_GT
	} scan_mode_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [7:0]  len;
		logic [31:0] start;
		logic        last;
	} tok_t;

	typedef struct packed {
		scan_mode_t          mode;
		logic [LEN_W-1:0]    len;
		logic [KW_COUNT-1:0] cand;
		logic [31:0]         origin;
		logic [31:0]         pos;
	} scan_state_t;

	typedef struct packed {
		logic [1:0] count;
		tok_t       tok0;
		tok_t       tok1;
	} step_res_t;

	// keyword lengths: int main if else while
	function automatic logic [2:0] kw_len(input logic [2:0] k);
		logic [2:0] r;
		unique case (k)
			3'd0:    r = 3'd3;
			3'd1:    r = 3'd4;
			3'd2:    r = 3'd2;
			3'd3:    r = 3'd4;
			3'd4:    r = 3'd5;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// character p of keyword k
	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
		logic [7:0] r;
		r = 8'h00;
		unique case (k)
			3'd0: begin
				unique case (p)
					3'd0:    r = 8'h69; // i
					3'd1:    r = 8'h6E; // n
					3'd2:    r = 8'h74; // t
					default: r = 8'h00;
				endcase
			end
			3'd1: begin
				unique case (p)
					3'd0:    r = 8'h6D; // m
					3'd1:    r = 8'h61; // a
					3'd2:    r = 8'h69; // i
					3'd3:    r = 8'h6E; // n
					default: r = 8'h00;
				endcase
			end
			3'd2: begin
				unique case (p)
					3'd0:    r = 8'h69; // i
					3'd1:    r = 8'h66; // f
					default: r = 8'h00;
				endcase
			end
			3'd3: begin
				unique case (p)
					3'd0:    r = 8'h65; // e
					3'd1:    r = 8'h6C; // l
					3'd2:    r = 8'h73; // s
					3'd3:    r = 8'h65; // e
					default: r = 8'h00;
				endcase
			end
			3'd4: begin
				unique case (p)
					3'd0:    r = 8'h77; // w
					3'd1:    r = 8'h68; // h
					3'd2:    r = 8'h69; // i
					3'd3:    r = 8'h6C; // l
					3'd4:    r = 8'h65; // e
					default: r = 8'h00;
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/kts_if.sv @@
// ----------------------------------------------------------------------------
// kts_byte_if / kts_token_if
// valid/ready channels for source bytes and token records
// ----------------------------------------------------------------------------
interface kts_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       final_byte;

	modport source (output valid, output byte_value, output final_byte, input ready);
	modport sink   (input valid, input byte_value, input final_byte, output ready);
endinterface

interface kts_token_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [7:0]  token_length;
	logic [31:0] token_start;
	logic        last_of_run;

	modport source (output valid, output token_kind, output token_length,
		output token_start, output last_of_run, input ready);
	modport sink   (input valid, input token_kind, input token_length,
		input token_start, input last_of_run, output ready);
endinterface

@@ rtl/kts_step.sv @@
// ----------------------------------------------------------------------------
// kts_step
// one scanner step: next state and up to two token records for one byte
// ----------------------------------------------------------------------------
module kts_step
	import kts_pkg::*;
(
	input  scan_state_t cur,
	input  logic [7:0]  byte_value,
	input  logic        final_byte,
	output scan_state_t nxt,
	output step_res_t   res
);

	function automatic logic [KW_COUNT-1:0] cand_upd(
		input logic [KW_COUNT-1:0] cand,
		input logic [LEN_W-1:0]    p,
		input logic [7:0]          c
	);
		logic [KW_COUNT-1:0] r;
		r = cand;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (p >= LEN_W'(kw_len(3'(k))) || kw_char(3'(k), p[2:0]) != c) begin
				r[k] = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic logic [4:0] ident_kind(
		input logic [KW_COUNT-1:0] cand,
		input logic [LEN_W-1:0]    len
	);
		logic [4:0] r;
		r = K_ID;
		// lowest keyword index wins
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (cand[k] && len == LEN_W'(kw_len(3'(k)))) begin
				r = 5'(k);
			end
		end
		return r;
	endfunction

	// record for whatever token the state holds open
	function automatic tok_t flush_tok(input scan_state_t s);
		tok_t t;
		t.start = s.origin;
		t.last  = 1'b0;
		t.len   = 8'd1;
		t.kind  = K_ASSIGN;
		unique case (s.mode)
			MODE_IDENT: begin
				t.kind = ident_kind(s.cand, s.len);
				t.len  = 8'(s.len);
			end
			MODE_LIT: begin
				t.kind = K_LIT;
				t.len  = 8'(s.len);
			end
			MODE_LT:  t.kind = K_LT;
			MODE_GT:  t.kind = K_GT;
			default:  t.kind = K_ASSIGN;
		endcase
		return t;
	endfunction

	logic             is_alpha;
	logic             is_num;
	logic             used;
	logic [LEN_W-1:0] len_inc;
	logic             a_vld;
	tok_t             a_tok;
	logic             b_vld;
	tok_t             b_tok;
	scan_state_t      mid;

	assign is_alpha = (byte_value >= 8'h61 && byte_value <= 8'h7A)
		|| (byte_value >= 8'h41 && byte_value <= 8'h5A) || byte_value == CH_UNDER;
	assign is_num   = byte_value >= 8'h30 && byte_value <= 8'h39;
	assign len_inc  = (cur.len < LEN_W'(MAX_TOKEN_LENGTH)) ? cur.len + 1'b1 : cur.len;

	always_comb begin
		mid   = cur;
		used  = 1'b0;
		a_vld = 1'b0;
		a_tok = flush_tok(cur);
		b_vld = 1'b0;
		b_tok = '{kind: K_PLUS, len: 8'd1, start: cur.pos, last: 1'b0};

		// pending token: extend it or close it
		unique case (cur.mode)
			MODE_IDENT: begin
				if (is_alpha || is_num) begin
					mid.len  = len_inc;
					mid.cand = cand_upd(cur.cand, cur.len, byte_value);
					used     = 1'b1;
				end else begin
					a_vld = 1'b1;
				end
			end
			MODE_LIT: begin
				if (is_num) begin
					mid.len = len_inc;
					used    = 1'b1;
				end else begin
					a_vld = 1'b1;
				end
			end
			MODE_EQ, MODE_LT, MODE_GT: begin
				a_vld = 1'b1;
				if (byte_value == CH_EQ) begin
					used       = 1'b1;
					a_tok.len  = 8'd2;
					a_tok.kind = (cur.mode == MODE_EQ) ? K_EQEQ :
						((cur.mode == MODE_LT) ? K_LE : K_GE);
					mid.mode   = MODE_IDLE;
					mid.len    = '0;
					mid.cand   = KW_ALL;
				end
			end
			default: ;
		endcase

		// byte not taken by the pending token starts afresh
		if (!used) begin
			mid.mode = MODE_IDLE;
			mid.len  = '0;
			mid.cand = KW_ALL;
			if (is_alpha) begin
				mid.mode   = MODE_IDENT;
				mid.origin = cur.pos;
				mid.len    = LEN_W'(1);
				mid.cand   = cand_upd(KW_ALL, '0, byte_value);
			end else if (is_num) begin
				mid.mode   = MODE_LIT;
				mid.origin = cur.pos;
				mid.len    = LEN_W'(1);
				mid.cand   = cand_upd(KW_ALL, '0, byte_value);
			end else if (byte_value == CH_EQ) begin
				mid.mode   = MODE_EQ;
				mid.origin = cur.pos;
				mid.len    = LEN_W'(1);
				mid.cand   = cand_upd(KW_ALL, '0, byte_value);
			end else if (byte_value == CH_LT) begin
				mid.mode   = MODE_LT;
				mid.origin = cur.pos;
				mid.len    = LEN_W'(1);
				mid.cand   = cand_upd(KW_ALL, '0, byte_value);
			end else if (byte_value == CH_GT) begin
				mid.mode   = MODE_GT;
				mid.origin = cur.pos;
				mid.len    = LEN_W'(1);
				mid.cand   = cand_upd(KW_ALL, '0, byte_value);
			end else begin
				b_vld = 1'b1;
				unique case (byte_value)
					CH_LPAREN: b_tok.kind = K_LPAREN;
					CH_RPAREN: b_tok.kind = K_RPAREN;
					CH_LBRACE: b_tok.kind = K_LBRACE;
					CH_RBRACE: b_tok.kind = K_RBRACE;
					CH_SEMI:   b_tok.kind = K_SEMI;
					CH_PLUS:   b_tok.kind = K_PLUS;
					CH_MINUS:  b_tok.kind = K_MINUS;
					default:   b_vld = 1'b0;
				endcase
			end
		end

		// end of text flushes and rewinds everything
		nxt = mid;
		if (final_byte) begin
			if (mid.mode != MODE_IDLE) begin
				b_vld = 1'b1;
				b_tok = flush_tok(mid);
			end
			nxt.mode   = MODE_IDLE;
			nxt.len    = '0;
			nxt.cand   = KW_ALL;
			nxt.origin = '0;
			nxt.pos    = '0;
		end else begin
			nxt.pos = cur.pos + 32'd1;
		end

		// pack up to two records
		res.count     = 2'(a_vld) + 2'(b_vld);
		res.tok0      = a_vld ? a_tok : b_tok;
		res.tok1      = b_tok;
		res.tok0.last = !(a_vld && b_vld);
		res.tok1.last = 1'b1;
	end

endmodule

@@ rtl/kts_fifo.sv @@
// ----------------------------------------------------------------------------
// kts_fifo
// small result queue, takes zero to two records a cycle, gives one
// ----------------------------------------------------------------------------
module kts_fifo
	import kts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] wr_count,
	input  tok_t       wr0,
	input  tok_t       wr1,
	input  logic       pop,
	output tok_t       head,
	output logic       not_empty,
	output logic       room2
);

	tok_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               do_pop;

	assign not_empty = count_q != '0;
	assign room2     = count_q <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
	assign head      = mem_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (wr_count != 2'd0) begin
			mem_q[wr_ptr_q] <= wr0;
		end
		if (wr_count == 2'd2) begin
			mem_q[wr_ptr_q + 1'b1] <= wr1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(wr_count);
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(do_pop);
			count_q  <= count_q + (FIFO_AW + 1)'(wr_count) - (FIFO_AW + 1)'(do_pop);
		end
	end

endmodule

@@ rtl/keyword_token_scanner_core.sv @@
// ----------------------------------------------------------------------------
// keyword_token_scanner_core
// byte-serial lexer giving token records for a small c-like language
// ----------------------------------------------------------------------------
// Source text enters one byte per beat on byte_in, final_byte marking the
// last byte of a text; token records leave one per beat on token_out. A byte
// is held in an input register, then a single combinational step updates the
// scanner state (mode, token length, keyword candidate mask, token origin and
// byte offset) and writes zero, one or two records into a four-entry result
// queue. A new byte is taken every cycle as long as the queue has room for two
// records, so the block runs at one byte per cycle; the output port, at one
// record per cycle, is the only limit when bytes yield two records. With the
// queue empty, the first record of a byte passes the input register and is
// written into the result queue before it appears on token_out. After the
// final byte any pending token is flushed and offsets restart at zero.
// ----------------------------------------------------------------------------
module keyword_token_scanner_core
	import kts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	kts_byte_if.sink    byte_in,
	kts_token_if.source token_out
);

	// input register
	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        fin_s1;

	// scanner state
	scan_state_t state_q;
	scan_state_t state_nxt;
	step_res_t   step_res;

	logic        room2;
	logic        adv;
	logic        not_empty;
	tok_t        head;

	// step fires once the queue can absorb the worst case of two records
	assign adv           = vld_s1 && room2;
	assign byte_in.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			vld_s1 <= byte_in.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			byte_s1 <= byte_in.byte_value;
			fin_s1  <= byte_in.final_byte;
		end
	end

	kts_step u_step (
		.cur        (state_q),
		.byte_value (byte_s1),
		.final_byte (fin_s1),
		.nxt        (state_nxt),
		.res        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode   <= MODE_IDLE;
			state_q.len    <= '0;
			state_q.cand   <= KW_ALL;
			state_q.origin <= '0;
			state_q.pos    <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	kts_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_count  (adv ? step_res.count : 2'd0),
		.wr0       (step_res.tok0),
		.wr1       (step_res.tok1),
		.pop       (token_out.ready),
		.head      (head),
		.not_empty (not_empty),
		.room2     (room2)
	);

	// output beat straight from the queue head
	assign token_out.valid        = not_empty;
	assign token_out.token_kind   = head.kind;
	assign token_out.token_length = head.len;
	assign token_out.token_start  = head.start;
	assign token_out.last_of_run  = head.last;

endmodule

@@ rtl/kts_checker.sv @@
// ----------------------------------------------------------------------------
// kts_checker
// port-level checks on the token output of the scanner
// ----------------------------------------------------------------------------
module kts_checker
	import kts_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [4:0]  token_kind,
	input logic [7:0]  token_length,
	input logic [31:0] token_start,
	input logic        last_of_run
);

	// stalled beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind)
		&& $stable(token_length) && $stable(token_start) && $stable(last_of_run))
		else $error("token beat changed while stalled");

	// no empty tokens and no unknown kinds
	a_kind_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> token_length != 8'd0 && token_kind <= K_MINUS)
		else $error("bad token kind or zero length");

	// keywords carry their own length
	a_kw_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == K_INT || token_kind == K_MAIN || token_kind == K_IF
		|| token_kind == K_ELSE || token_kind == K_WHILE)
		|-> token_length == 8'(kw_len(3'(token_kind))))
		else $error("keyword length mismatch");

	// operators and punctuation are one or two characters
	a_op_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind >= K_LPAREN
		|-> ((token_kind == K_EQEQ || token_kind == K_GE || token_kind == K_LE)
		? token_length == 8'd2 : token_length == 8'd1))
		else $error("operator length mismatch");

endmodule

bind keyword_token_scanner_core kts_checker u_kts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (token_out.valid),
	.out_ready    (token_out.ready),
	.token_kind   (token_out.token_kind),
	.token_length (token_out.token_length),
	.token_start  (token_out.token_start),
	.last_of_run  (token_out.last_of_run)
);
